// ----- hw/rtl/form_urlencoded_parser_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the form-urlencoded parser
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef FORM_URLENCODED_PARSER_TOP_MACROS_SVH
`define FORM_URLENCODED_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every clock edge outside reset
`define FUP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);
// antecedent implies consequent on the following edge
`define FUP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);
`else
`define FUP_ASSERT(label, clk, rst_n, prop, msg)
`define FUP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/fup_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fup_pkg
// Types, character codes and helpers for the form-urlencoded parser.
// ----------------------------------------------------------------------------
package fup_pkg;

    // result kinds
    localparam logic [1:0] KIND_NAME     = 2'd0;
    localparam logic [1:0] KIND_VALUE    = 2'd1;
    localparam logic [1:0] KIND_PAIR_END = 2'd2;
    localparam logic [1:0] KIND_LIST_END = 2'd3;

    // input actions
    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // escape progress
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_PCT   = 2'd1;
    localparam logic [1:0] PEND_DIGIT = 2'd2;

    localparam logic [7:0] CH_PLUS     = 8'h2b;
    localparam logic [7:0] CH_AMP      = 8'h26;
    localparam logic [7:0] CH_EQUAL    = 8'h3d;
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_QUESTION = 8'h3f;
    localparam logic [7:0] CH_SPACE    = 8'h20;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [15:0] pair_number;
        logic        run_last;
    } t_result;

    function automatic logic f_is_hex(input logic [7:0] b);
        return b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] f_hex_val(input logic [7:0] b);
        logic [3:0] v;
        if (b inside {[8'h30:8'h39]}) begin
            v = b[3:0];
        end else begin
            v = b[3:0] + 4'd9;   // 'a'/'A' have low nibble 1
        end
        return v;
    endfunction

    function automatic t_result f_slot(input logic [1:0] kind, input logic [7:0] b,
                                       input logic [15:0] pn);
        t_result r;
        r.kind        = kind;
        r.out_byte    = b;
        r.pair_number = pn;
        r.run_last    = 1'b0;
        return r;
    endfunction

endpackage

// ----- hw/rtl/fup_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fup_in_if
// Input byte channel: one raw byte or an end-of-string mark per transfer.
// ----------------------------------------------------------------------------
interface fup_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

// ----- hw/rtl/fup_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fup_out_if
// Result channel: decoded bytes, pair ends and list ends.
// ----------------------------------------------------------------------------
interface fup_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [15:0] pair_number;
    logic        run_last;

    modport source (output valid, output kind, output out_byte, output pair_number,
                    output run_last, input ready);
    modport sink   (input valid, input kind, input out_byte, input pair_number,
                    input run_last, output ready);
endinterface

// ----- hw/rtl/fup_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fup_cfg_if
// Configuration write channel for the single control register.
// ----------------------------------------------------------------------------
interface fup_cfg_if;
    logic valid;
    logic ready;
    logic strip_leading_question;

    modport source (output valid, output strip_leading_question, input ready);
    modport sink   (input valid, input strip_leading_question, output ready);
endinterface

// ----- hw/rtl/form_urlencoded_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// form_urlencoded_parser_top
// Streaming form-urlencoded parser: bytes in, decoded name/value bytes and
// pair/list marks out.
// ----------------------------------------------------------------------------
// One input byte (or end mark) is taken per cycle while i_in.ready is high.
// A taken item sits in an input register until it is decoded against the
// parse state, and its zero to four results are written at once into an
// 8-entry result queue; results leave one per cycle while o_out.ready is
// high, so the output side sets the rate when items produce more than one
// result. An item is decoded only when the queue has four free entries;
// otherwise it waits in the input register and i_in.ready drops. The first
// result of an item reaches the output through the input register and then
// the queue. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "form_urlencoded_parser_top_macros.svh"

module form_urlencoded_parser_top
    import fup_pkg::*;
#(
    parameter int PAIR_INDEX_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fup_in_if.sink      i_in,
    fup_cfg_if.sink     i_cfg,
    fup_out_if.source   o_out
);

    localparam int          Q_DEPTH = 8;
    localparam int          Q_PTR_W = $clog2(Q_DEPTH);
    localparam int          Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam int          MAX_RES = 4;
    localparam logic [Q_CNT_W-1:0] Q_ROOM_LIMIT = Q_CNT_W'(Q_DEPTH - MAX_RES);
    localparam logic [PAIR_INDEX_BITS-1:0] PAIR_MAX = '1;

    // configuration
    logic r_strip;

    // input register
    logic       r_in_valid;
    logic       r_in_action;
    logic [7:0] r_in_byte;

    // parse state
    logic                       r_in_value;
    logic                       r_name_nonempty;
    logic [1:0]                 r_pend_count;
    logic [7:0]                 r_pend_hex;
    logic [PAIR_INDEX_BITS-1:0] r_pair_cnt;
    logic                       r_at_start;

    logic                       n_in_value;
    logic                       n_name_nonempty;
    logic [1:0]                 n_pend_count;
    logic [7:0]                 n_pend_hex;
    logic [PAIR_INDEX_BITS-1:0] n_pair_cnt;
    logic                       n_at_start;

    // result queue
    t_result              r_queue [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;

    t_result   w_slot [MAX_RES];
    logic [2:0] w_nres;
    logic       w_proc;
    logic       w_pop;

    assign w_proc     = r_in_valid && (r_count <= Q_ROOM_LIMIT);
    assign w_pop      = o_out.valid && o_out.ready;
    assign i_in.ready = !r_in_valid || w_proc;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = (r_count != '0);
    assign o_out.kind        = r_queue[r_rd_ptr].kind;
    assign o_out.out_byte    = r_queue[r_rd_ptr].out_byte;
    assign o_out.pair_number = r_queue[r_rd_ptr].pair_number;
    assign o_out.run_last    = r_queue[r_rd_ptr].run_last;

    // decode of one item: at most two literal bytes, then one byte through
    // the normal path, or the closing sequence of an end mark
    always_comb begin
        logic                       iv;
        logic                       nn;
        logic [2:0]                 n;
        logic                       lit0_en;
        logic                       lit1_en;
        logic [7:0]                 lit0;
        logic [7:0]                 lit1;
        logic                       do_cons;
        logic                       do_end;
        logic [PAIR_INDEX_BITS-1:0] cnt;
        logic [7:0]                 b;

        iv      = r_in_value;
        nn      = r_name_nonempty;
        cnt     = r_pair_cnt;
        b       = r_in_byte;
        n       = 3'd0;
        lit0_en = 1'b0;
        lit1_en = 1'b0;
        lit0    = CH_PERCENT;
        lit1    = r_pend_hex;
        do_cons = 1'b0;
        do_end  = 1'b0;
        n_pend_count = r_pend_count;
        n_pend_hex   = r_pend_hex;
        n_at_start   = r_at_start;
        for (int k = 0; k < MAX_RES; k++) begin
            w_slot[k] = f_slot(KIND_NAME, 8'h00, 16'h0000);
        end

        if (r_in_action == ACT_DATA) begin
            n_at_start = 1'b0;
            if (!(r_at_start && r_strip && (b == CH_QUESTION))) begin
                case (r_pend_count)
                    PEND_PCT: begin
                        if (f_is_hex(b)) begin
                            n_pend_count = PEND_DIGIT;
                            n_pend_hex   = b;
                        end else begin
                            n_pend_count = PEND_NONE;
                            lit0_en      = 1'b1;
                            do_cons      = 1'b1;
                        end
                    end
                    PEND_DIGIT: begin
                        n_pend_count = PEND_NONE;
                        lit0_en      = 1'b1;
                        if (f_is_hex(b)) begin
                            lit0 = {f_hex_val(r_pend_hex), f_hex_val(b)};
                        end else begin
                            // held digit is always hex, so it is a plain byte
                            lit1_en = 1'b1;
                            do_cons = 1'b1;
                        end
                    end
                    default: begin
                        n_pend_count = PEND_NONE;
                        do_cons      = 1'b1;
                    end
                endcase
            end
        end else begin
            // escape cut short by the end mark: flush it as literals
            lit0_en = (r_pend_count == PEND_PCT) || (r_pend_count == PEND_DIGIT);
            lit1_en = (r_pend_count == PEND_DIGIT);
            do_end  = 1'b1;
        end

        if (lit0_en) begin
            w_slot[n[1:0]] = f_slot(iv ? KIND_VALUE : KIND_NAME, lit0, 16'(cnt));
            nn = nn || !iv;
            n  = n + 3'd1;
        end
        if (lit1_en) begin
            w_slot[n[1:0]] = f_slot(iv ? KIND_VALUE : KIND_NAME, lit1, 16'(cnt));
            nn = nn || !iv;
            n  = n + 3'd1;
        end

        if (do_cons) begin
            if (b == CH_AMP) begin
                if (iv || nn) begin
                    w_slot[n[1:0]] = f_slot(KIND_PAIR_END, 8'h00, 16'(cnt));
                    n   = n + 3'd1;
                    cnt = (cnt != PAIR_MAX) ? cnt + 1'b1 : cnt;
                    iv  = 1'b0;
                    nn  = 1'b0;
                end
            end else if ((b == CH_EQUAL) && !iv) begin
                iv = 1'b1;
            end else if (b == CH_PERCENT) begin
                n_pend_count = PEND_PCT;
            end else begin
                w_slot[n[1:0]] = f_slot(iv ? KIND_VALUE : KIND_NAME,
                                        (b == CH_PLUS) ? CH_SPACE : b, 16'(cnt));
                nn = nn || !iv;
                n  = n + 3'd1;
            end
        end

        if (do_end) begin
            if (iv || nn) begin
                w_slot[n[1:0]] = f_slot(KIND_PAIR_END, 8'h00, 16'(cnt));
                n   = n + 3'd1;
                cnt = (cnt != PAIR_MAX) ? cnt + 1'b1 : cnt;
            end
            w_slot[n[1:0]] = f_slot(KIND_LIST_END, 8'h00, 16'(cnt));
            n            = n + 3'd1;
            iv           = 1'b0;
            nn           = 1'b0;
            cnt          = '0;
            n_pend_count = PEND_NONE;
            n_at_start   = 1'b1;
        end

        if (n != 3'd0) begin
            w_slot[2'(n - 3'd1)].run_last = 1'b1;
        end

        w_nres          = n;
        n_in_value      = iv;
        n_name_nonempty = nn;
        n_pair_cnt      = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip         <= 1'b1;
            r_in_valid      <= 1'b0;
            r_in_value      <= 1'b0;
            r_name_nonempty <= 1'b0;
            r_pend_count    <= PEND_NONE;
            r_pair_cnt      <= '0;
            r_at_start      <= 1'b1;
            r_wr_ptr        <= '0;
            r_rd_ptr        <= '0;
            r_count         <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_strip <= i_cfg.strip_leading_question;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_proc) begin
                r_in_value      <= n_in_value;
                r_name_nonempty <= n_name_nonempty;
                r_pend_count    <= n_pend_count;
                r_pair_cnt      <= n_pair_cnt;
                r_at_start      <= n_at_start;
                r_wr_ptr        <= r_wr_ptr + Q_PTR_W'(w_proc ? w_nres : 3'd0);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + Q_CNT_W'(w_proc ? w_nres : 3'd0)
                       - Q_CNT_W'(w_pop);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_action <= i_in.action;
            r_in_byte   <= i_in.data_byte;
        end
        if (w_proc) begin
            r_pend_hex <= n_pend_hex;
            for (int k = 0; k < MAX_RES; k++) begin
                if (3'(k) < w_nres) begin
                    r_queue[r_wr_ptr + Q_PTR_W'(k)] <= w_slot[k];
                end
            end
        end
    end

    `FUP_ASSERT(a_queue_bound, i_clk, i_rst_n, r_count <= Q_CNT_W'(Q_DEPTH),
                "result queue over capacity")
    `FUP_ASSERT(a_room_on_decode, i_clk, i_rst_n,
                !w_proc || (r_count <= Q_ROOM_LIMIT),
                "item decoded without room for its results")
    `FUP_ASSERT(a_held_digit_hex, i_clk, i_rst_n,
                (r_pend_count != PEND_DIGIT) || f_is_hex(r_pend_hex),
                "held escape digit is not hex")
    `FUP_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, w_proc && (r_in_action == ACT_END),
                     r_at_start && (r_pair_cnt == '0) && (r_pend_count == PEND_NONE),
                     "parse state not cleared after end mark")

endmodule
